/* hw/rtl/lrtm_pkg.sv */
// Shared constants, codes and field widths for the linear recurrence term block.
package lrtm_pkg;

  // Field widths
  localparam int VALUE_W = 31;
  localparam int RAW_W   = 64;
  localparam int ORDER_W = 5;
  localparam int SLOT_W  = 5;
  localparam int OP_W    = 2;

  // Request opcodes
  localparam logic [OP_W-1:0] OP_LOAD_COEF = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_INIT = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY     = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR     = 2'd3;

  // Configuration register indexes
  localparam logic REG_ORDER   = 1'b0;
  localparam logic REG_MODULUS = 1'b1;

  // What a result leaving the modular unit is for
  localparam logic [1:0] KIND_MAT  = 2'd0;
  localparam logic [1:0] KIND_DOT  = 2'd1;
  localparam logic [1:0] KIND_COEF = 2'd2;
  localparam logic [1:0] KIND_INIT = 2'd3;

endpackage

/* hw/rtl/lrtm_ram.sv */
// Generic RAM: one write port, two registered read ports.
module lrtm_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 289
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] ra_addr,
  output logic [WIDTH-1:0]         ra_data,
  input  logic [$clog2(DEPTH)-1:0] rb_addr,
  output logic [WIDTH-1:0]         rb_data
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    ra_data <= mem[ra_addr];
    rb_data <= mem[rb_addr];
  end

endmodule

/* hw/rtl/lrtm_modmul.sv */
// Pipelined modular unit: (x*y) mod m or wide mod m, one request per cycle.
module lrtm_modmul #(
  parameter type tag_t = logic
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_wide,
  input  logic [lrtm_pkg::VALUE_W-1:0]  x,
  input  logic [lrtm_pkg::VALUE_W-1:0]  y,
  input  logic [lrtm_pkg::RAW_W-1:0]    wide_value,
  input  tag_t                          in_tag,
  input  logic [lrtm_pkg::VALUE_W-1:0]  modulus,
  output logic                          out_valid,
  output logic [lrtm_pkg::VALUE_W-1:0]  remainder,
  output tag_t                          out_tag
);
  import lrtm_pkg::*;

  logic [RAW_W-1:0]     w_q [0:RAW_W];
  logic [VALUE_W-1:0]   r_q [0:RAW_W];
  logic                 v_q [0:RAW_W];
  tag_t                 g_q [0:RAW_W];
  logic [2*VALUE_W-1:0] prod;

  assign prod = x * y;

  // Stage 0: product or wide operand
  always_ff @(posedge clk) begin
    if (rst) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= in_valid;
    end
    w_q[0] <= in_wide ? wide_value : RAW_W'(prod);
    r_q[0] <= '0;
    g_q[0] <= in_tag;
  end

  // One restoring step per stage, most significant bit first
  for (genvar s = 1; s <= RAW_W; s++) begin : g_step
    logic [VALUE_W:0] trial;
    logic [VALUE_W:0] diff;
    logic             ge;

    assign trial = {r_q[s-1], w_q[s-1][RAW_W-1]};
    assign diff  = trial - {1'b0, modulus};
    assign ge    = trial >= {1'b0, modulus};

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[s] <= 1'b0;
      end else begin
        v_q[s] <= v_q[s-1];
      end
      r_q[s] <= ge ? diff[VALUE_W-1:0] : trial[VALUE_W-1:0];
      w_q[s] <= w_q[s-1] << 1;
      g_q[s] <= g_q[s-1];
    end
  end

  assign out_valid = v_q[RAW_W];
  assign remainder = r_q[RAW_W];
  assign out_tag   = g_q[RAW_W];

endmodule

/* hw/rtl/linear_recurrence_term_mod_core.sv */
// Top level: stores, query sequencer, matrix RAMs and the shared modular unit.
//
//  channel   ports                                        handshake
//  request   start, op, slot, raw_value, term_index       start && !busy
//  result    done, term                                   done, one cycle
//  config    cfg_we, cfg_index, cfg_data                  cfg_we
//
// Clear and direct queries (n < k, or k = 0) complete in idle; a load waits
// in S_LOAD for the 64-step modular reduction pipeline to drain. A matrix query
// finds the exponent's leading one, fills the companion matrix, squares and
// multiplies per exponent bit, ends with a dot product; the shared unit takes one
// product a cycle. rst is synchronous; stores clear at once. Results cannot stall.
module linear_recurrence_term_mod_core #(
  parameter int MAX_ORDER  = 16,
  parameter int INDEX_BITS = 31
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [lrtm_pkg::OP_W-1:0]     op,
  input  logic [lrtm_pkg::SLOT_W-1:0]   slot,
  input  logic signed [lrtm_pkg::RAW_W-1:0] raw_value,
  input  logic [lrtm_pkg::VALUE_W-1:0]  term_index,
  output logic                          done,
  output logic [lrtm_pkg::VALUE_W-1:0]  term,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [lrtm_pkg::VALUE_W-1:0]  cfg_data
);
  import lrtm_pkg::*;

  localparam int DIM = MAX_ORDER + 1;
  localparam int CW  = $clog2(MAX_ORDER + 1);
  localparam int AW  = $clog2(DIM * DIM);
  localparam int IIW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int BW  = (INDEX_BITS > 1) ? $clog2(INDEX_BITS) : 1;
  localparam int FW  = $clog2(RAW_W + 4);

  typedef struct packed {
    logic [1:0]        kind;
    logic              first;
    logic              last;
    logic              neg;
    logic              dst;
    logic [AW-1:0]     addr;
    logic [SLOT_W-1:0] slot;
  } mac_tag_t;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_LOAD     = 4'd1;
  localparam logic [3:0] S_FIND     = 4'd2;
  localparam logic [3:0] S_FILL     = 4'd3;
  localparam logic [3:0] S_NEXT     = 4'd4;
  localparam logic [3:0] S_SQ       = 4'd5;
  localparam logic [3:0] S_SQ_WAIT  = 4'd6;
  localparam logic [3:0] S_MUL      = 4'd7;
  localparam logic [3:0] S_MUL_WAIT = 4'd8;
  localparam logic [3:0] S_DOT      = 4'd9;
  localparam logic [3:0] S_DOT_WAIT = 4'd10;

  // Companion matrix entry
  function automatic logic [VALUE_W-1:0] base_entry(logic [CW-1:0] row,
      logic [CW-1:0] col, logic [CW-1:0] kk, logic [VALUE_W-1:0] c);
    logic hit;
    if (row == '0) begin
      return c;
    end
    if (row < kk) begin
      hit = ({1'b0, col} + 1'b1) == {1'b0, row};
    end else begin
      hit = (row == kk) && (col == kk);
    end
    return hit ? VALUE_W'(1) : '0;
  endfunction

  function automatic logic [AW-1:0] maddr(logic [CW-1:0] r, logic [CW-1:0] c);
    return AW'(int'(r) * DIM + int'(c));
  endfunction

  // Configuration
  logic [ORDER_W-1:0] order;
  logic [VALUE_W-1:0] modulus;
  logic [CW-1:0]      k;
  logic [VALUE_W-1:0] m;

  always_ff @(posedge clk) begin
    if (rst) begin
      order   <= '0;
      modulus <= VALUE_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORDER:   order   <= cfg_data[ORDER_W-1:0];
        REG_MODULUS: modulus <= cfg_data;
        default:     ;
      endcase
    end
  end

  assign k = (order > ORDER_W'(MAX_ORDER)) ? CW'(MAX_ORDER) : CW'(order);
  assign m = (modulus == '0) ? VALUE_W'(1) : modulus;

  // Sequencer state
  logic [3:0]            state;
  logic                  cur;
  logic [CW-1:0]         i_cnt, j_cnt, t_cnt;
  logic [INDEX_BITS-1:0] e;
  logic [BW-1:0]         b;
  logic [FW-1:0]         inflight;
  logic [VALUE_W-1:0]    coef [0:MAX_ORDER];
  logic [VALUE_W-1:0]    init [0:MAX_ORDER-1];
  logic [VALUE_W-1:0]    acc;

  logic                  accept;
  logic [INDEX_BITS-1:0] n;
  logic                  load_go;
  logic                  issuing;
  logic                  drained;
  logic [CW-1:0]         jend;
  logic [CW-1:0]         ii;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign n       = term_index[INDEX_BITS-1:0];
  assign load_go = accept &&
                   ((op == OP_LOAD_COEF && slot <= SLOT_W'(MAX_ORDER)) ||
                    (op == OP_LOAD_INIT && slot <  SLOT_W'(MAX_ORDER)));
  assign issuing = (state == S_SQ) || (state == S_MUL) || (state == S_DOT);
  assign jend    = (state == S_DOT) ? '0 : k;
  assign ii      = k - CW'(1) - t_cnt;

  // Issue side, aligned with the RAM read latency
  logic               iss_q;
  mac_tag_t           tag_q;
  logic               src_q;
  logic               rhs_ram_q;
  logic [VALUE_W-1:0] rhs_c_q;
  mac_tag_t           iss_tag;
  logic [VALUE_W-1:0] rhs_c;

  always_comb begin
    iss_tag       = '0;
    iss_tag.kind  = (state == S_DOT) ? KIND_DOT : KIND_MAT;
    iss_tag.first = (t_cnt == '0);
    iss_tag.last  = (t_cnt == k);
    iss_tag.dst   = (state == S_SQ) ? !cur : cur;
    iss_tag.addr  = maddr(i_cnt, j_cnt);
    if (state == S_DOT) begin
      rhs_c = (t_cnt == k) ? VALUE_W'(1) : init[ii[IIW-1:0]];
    end else begin
      rhs_c = base_entry(t_cnt, j_cnt, k, coef[j_cnt]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iss_q <= 1'b0;
    end else begin
      iss_q <= issuing;
    end
    tag_q     <= iss_tag;
    src_q     <= (state == S_MUL) ? !cur : cur;
    rhs_ram_q <= (state == S_SQ);
    rhs_c_q   <= rhs_c;
  end

  // Matrix RAMs
  logic [AW-1:0]      rd_a_addr, rd_b_addr, wr_addr;
  logic [VALUE_W-1:0] rd0_a, rd0_b, rd1_a, rd1_b, wr_data;
  logic               we0, we1;

  assign rd_a_addr = maddr(i_cnt, t_cnt);
  assign rd_b_addr = maddr(t_cnt, j_cnt);

  lrtm_ram #(.WIDTH(VALUE_W), .DEPTH(DIM * DIM)) u_ram0 (
    .clk(clk), .we(we0), .waddr(wr_addr), .wdata(wr_data),
    .ra_addr(rd_a_addr), .ra_data(rd0_a), .rb_addr(rd_b_addr), .rb_data(rd0_b)
  );

  lrtm_ram #(.WIDTH(VALUE_W), .DEPTH(DIM * DIM)) u_ram1 (
    .clk(clk), .we(we1), .waddr(wr_addr), .wdata(wr_data),
    .ra_addr(rd_a_addr), .ra_data(rd1_a), .rb_addr(rd_b_addr), .rb_data(rd1_b)
  );

  // Shared modular unit
  logic               u_valid;
  logic [VALUE_W-1:0] u_x, u_y;
  logic [RAW_W-1:0]   mag;
  mac_tag_t           load_tag, u_tag, o_tag;
  logic               o_valid;
  logic [VALUE_W-1:0] o_rem;

  always_comb begin
    load_tag       = '0;
    load_tag.kind  = (op == OP_LOAD_COEF) ? KIND_COEF : KIND_INIT;
    load_tag.first = 1'b1;
    load_tag.last  = 1'b1;
    load_tag.neg   = raw_value[RAW_W-1];
    load_tag.slot  = slot;
  end

  assign mag     = raw_value[RAW_W-1] ? (~raw_value + 1'b1) : raw_value;
  assign u_valid = iss_q || load_go;
  assign u_x     = src_q ? rd1_a : rd0_a;
  assign u_y     = rhs_ram_q ? (cur ? rd1_b : rd0_b) : rhs_c_q;
  assign u_tag   = load_go ? load_tag : tag_q;

  lrtm_modmul #(.tag_t(mac_tag_t)) u_modmul (
    .clk(clk), .rst(rst), .in_valid(u_valid), .in_wide(load_go),
    .x(u_x), .y(u_y), .wide_value(mag), .in_tag(u_tag), .modulus(m),
    .out_valid(o_valid), .remainder(o_rem), .out_tag(o_tag)
  );

  // Accumulate and reduce at the unit output
  logic [VALUE_W:0]   sum, red;
  logic [VALUE_W-1:0] accv, loadv;
  logic               mat_wr, fill_we;

  assign sum   = (o_tag.first ? '0 : {1'b0, acc}) + {1'b0, o_rem};
  assign red   = (sum >= {1'b0, m}) ? (sum - {1'b0, m}) : sum;
  assign accv  = red[VALUE_W-1:0];
  assign loadv = (o_tag.neg && o_rem != '0) ? (m - o_rem) : o_rem;

  assign mat_wr  = o_valid && o_tag.last && (o_tag.kind == KIND_MAT);
  assign fill_we = (state == S_FILL);
  assign we0     = fill_we ? !cur : (mat_wr && !o_tag.dst);
  assign we1     = fill_we ?  cur : (mat_wr &&  o_tag.dst);
  assign wr_addr = fill_we ? maddr(i_cnt, j_cnt) : o_tag.addr;
  assign wr_data = fill_we ? base_entry(i_cnt, j_cnt, k, coef[j_cnt]) : accv;

  always_ff @(posedge clk) begin
    if (o_valid) begin
      acc <= accv;
    end
  end

  // In-flight count for draining between passes
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + FW'(u_valid) - FW'(o_valid);
    end
  end

  assign drained = (inflight == '0) && !iss_q;

  // Coefficient and initial term stores
  always_ff @(posedge clk) begin
    if (rst || (accept && op == OP_CLEAR)) begin
      for (int x = 0; x <= MAX_ORDER; x++) begin
        coef[x] <= '0;
      end
      for (int x = 0; x < MAX_ORDER; x++) begin
        init[x] <= '0;
      end
    end else if (o_valid && o_tag.kind == KIND_COEF) begin
      coef[o_tag.slot[CW-1:0]] <= loadv;
    end else if (o_valid && o_tag.kind == KIND_INIT) begin
      init[o_tag.slot[IIW-1:0]] <= loadv;
    end
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (accept && op == OP_QUERY && (n < INDEX_BITS'(k) || k == '0)) ||
              (o_valid && o_tag.last && o_tag.kind == KIND_DOT);
    end
    if (accept && op == OP_QUERY) begin
      term <= (n < INDEX_BITS'(k)) ? init[n[IIW-1:0]] : coef[0];
    end else if (o_valid && o_tag.last && o_tag.kind == KIND_DOT) begin
      term <= accv;
    end
  end

  // Query sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cur   <= 1'b0;
      i_cnt <= '0;
      j_cnt <= '0;
      t_cnt <= '0;
      e     <= '0;
      b     <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          i_cnt <= '0;
          j_cnt <= '0;
          t_cnt <= '0;
          cur   <= 1'b0;
          if (load_go) begin
            state <= S_LOAD;
          end else if (accept && op == OP_QUERY && n >= INDEX_BITS'(k) && k != '0) begin
            e     <= n - INDEX_BITS'(k) + 1'b1;
            b     <= BW'(INDEX_BITS - 1);
            state <= S_FIND;
          end
        end
        S_LOAD: begin
          if (drained) begin
            state <= S_IDLE;
          end
        end
        // Leading one of the exponent, one bit a cycle
        S_FIND: begin
          if (e[b]) begin
            state <= S_FILL;
          end else begin
            b <= b - 1'b1;
          end
        end
        // Companion matrix into the power RAM
        S_FILL: begin
          if (j_cnt == k) begin
            j_cnt <= '0;
            if (i_cnt == k) begin
              i_cnt <= '0;
              state <= S_NEXT;
            end else begin
              i_cnt <= i_cnt + 1'b1;
            end
          end else begin
            j_cnt <= j_cnt + 1'b1;
          end
        end
        S_NEXT: begin
          if (b == '0) begin
            state <= S_DOT;
          end else begin
            b     <= b - 1'b1;
            state <= S_SQ;
          end
        end
        S_SQ, S_MUL, S_DOT: begin
          if (t_cnt == k) begin
            t_cnt <= '0;
            if (j_cnt == jend) begin
              j_cnt <= '0;
              if (i_cnt == jend) begin
                i_cnt <= '0;
                case (state)
                  S_SQ:    state <= S_SQ_WAIT;
                  S_MUL:   state <= S_MUL_WAIT;
                  default: state <= S_DOT_WAIT;
                endcase
              end else begin
                i_cnt <= i_cnt + 1'b1;
              end
            end else begin
              j_cnt <= j_cnt + 1'b1;
            end
          end else begin
            t_cnt <= t_cnt + 1'b1;
          end
        end
        S_SQ_WAIT: begin
          if (drained) begin
            if (e[b]) begin
              state <= S_MUL;
            end else begin
              cur   <= !cur;
              state <= S_NEXT;
            end
          end
        end
        S_MUL_WAIT: begin
          if (drained) begin
            state <= S_NEXT;
          end
        end
        S_DOT_WAIT: begin
          if (drained) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
